[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; expands to nothing when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define JETP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define JETP_ASSERT_ALL(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");
`else
`define JETP_ASSERT_RST(lbl, prop)
`define JETP_ASSERT_ALL(lbl, prop)
`endif

`endif

[rtl/jetp_pkg.sv]
// shared types, constants and helper functions for the julia escape-time pixel unit
// no dependencies
`timescale 1ns / 1ps

package jetp_pkg;

    localparam int          FRAC_BITS = 26;
    localparam logic [16:0] MAX_ITER  = 17'd1023;
    localparam int          ADDR_W    = 5;
    localparam int          DATA_W    = 32;

    localparam logic signed [63:0] FOUR_FX = 64'sd4 <<< FRAC_BITS;

    localparam logic [9:0]  RST_ITER_LIMIT = 10'd100;
    localparam logic [9:0]  RST_CENTER_X   = 10'd512;
    localparam logic [9:0]  RST_CENTER_Y   = 10'd512;
    localparam logic [30:0] RST_PIXEL_STEP = 31'd262144;

    typedef enum logic [2:0] {
        REG_C_REAL     = 3'd0,
        REG_C_IMAG     = 3'd1,
        REG_ITER_LIMIT = 3'd2,
        REG_CENTER_X   = 3'd3,
        REG_CENTER_Y   = 3'd4,
        REG_PIXEL_STEP = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
        logic [9:0]         iter_limit;
        logic [9:0]         center_x;
        logic [9:0]         center_y;
        logic [30:0]        pixel_step;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_START,
        S_MUL,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic map_sel;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic escape;
        logic at_limit;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [9:0] eff_limit(input logic [9:0] lim);
        logic [9:0] r;
        if ({7'b0, lim} < MAX_ITER) begin
            r = lim;
        end else begin
            r = MAX_ITER[9:0];
        end
        return r;
    endfunction

endpackage

[rtl/julia_escape_time_pixel.sv]
// Julia set escape-time unit: one pixel coordinate in, iteration count and escaped flag
// out. Each pixel is mapped to a Q6.26 start point, then z = z^2 + c is iterated with
// three shared 32x32 multipliers; each iteration is a multiply step, then an evaluate
// and update step. A pixel passes map and start, then loops multiply and evaluate until
// it escapes or hits the limit; the result beat is registered from the evaluate state,
// which an output stall holds. The next pixel is taken once the unit is back in idle,
// even as the old result still sits in the output register. c, the limit, centers and
// step are set over the APB port and must only be written while no pixel is in flight.
// depends on jetp_pkg, jetp_cfg, jetp_ctrl, jetp_dp and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module julia_escape_time_pixel
    import jetp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [9:0]        i_pixel_x,
    input  logic [9:0]        i_pixel_y,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [9:0]        o_iter_count,
    output logic              o_escaped,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       w_cfg;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [9:0] w_eff_lim;

    assign w_eff_lim = eff_limit(w_cfg.iter_limit);

    jetp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    jetp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    jetp_dp u_dp (
        .i_clk        (i_clk),
        .i_cfg        (w_cfg),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_iter_count (o_iter_count),
        .o_escaped    (o_escaped)
    );

    // an accepted beat keeps the unit busy on the following cycle
    `JETP_ASSERT_RST(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // a pixel that did not escape ran exactly to the effective limit
    `JETP_ASSERT_RST(a_limit_count, (o_out_valid && !o_escaped) |-> (o_iter_count == w_eff_lim))
    // an escaped pixel never reports more iterations than the limit
    `JETP_ASSERT_RST(a_escape_count, (o_out_valid && o_escaped) |-> (o_iter_count <= w_eff_lim))
    // no result appears except from the evaluate step
    `JETP_ASSERT_ALL(a_valid_source, $rose(o_out_valid) |-> $past(w_cmd.finish))

endmodule

[rtl/jetp_cfg.sv]
// apb-style configuration register file
// depends on jetp_pkg
`timescale 1ns / 1ps

module jetp_cfg
    import jetp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c_real     <= '0;
            r_cfg.c_imag     <= '0;
            r_cfg.iter_limit <= RST_ITER_LIMIT;
            r_cfg.center_x   <= RST_CENTER_X;
            r_cfg.center_y   <= RST_CENTER_Y;
            r_cfg.pixel_step <= RST_PIXEL_STEP;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_C_REAL:     r_cfg.c_real     <= pwdata;
                REG_C_IMAG:     r_cfg.c_imag     <= pwdata;
                REG_ITER_LIMIT: r_cfg.iter_limit <= pwdata[9:0];
                REG_CENTER_X:   r_cfg.center_x   <= pwdata[9:0];
                REG_CENTER_Y:   r_cfg.center_y   <= pwdata[9:0];
                REG_PIXEL_STEP: r_cfg.pixel_step <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_C_REAL:     prdata = r_cfg.c_real;
            REG_C_IMAG:     prdata = r_cfg.c_imag;
            REG_ITER_LIMIT: prdata = {22'b0, r_cfg.iter_limit};
            REG_CENTER_X:   prdata = {22'b0, r_cfg.center_x};
            REG_CENTER_Y:   prdata = {22'b0, r_cfg.center_y};
            REG_PIXEL_STEP: prdata = {1'b0, r_cfg.pixel_step};
            default:        prdata = '0;
        endcase
    end

endmodule

[rtl/jetp_dp.sv]
// datapath: pixel mapping, shared multiplier set, escape test and z update
// depends on jetp_pkg
`timescale 1ns / 1ps

module jetp_dp
    import jetp_pkg::*;
(
    input  logic       i_clk,
    input  t_cfg       i_cfg,
    input  logic [9:0] i_pixel_x,
    input  logic [9:0] i_pixel_y,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic [9:0] o_iter_count,
    output logic       o_escaped
);

    logic signed [10:0] r_dx;
    logic signed [10:0] r_dy;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic signed [63:0] r_p0;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_p2;
    logic [9:0]         r_count;
    logic [9:0]         r_limit;
    logic [9:0]         r_res_count;
    logic               r_res_esc;

    logic signed [31:0] w_step;
    logic signed [31:0] w_a0;
    logic signed [31:0] w_b0;
    logic signed [31:0] w_a1;
    logic signed [31:0] w_b1;
    logic signed [63:0] w_sr;
    logic signed [63:0] w_si;
    logic signed [63:0] w_cross;
    logic signed [63:0] w_mag;
    logic signed [31:0] w_nr;
    logic signed [31:0] w_ni;

    assign w_step = $signed({1'b0, i_cfg.pixel_step});

    // map cycle reuses the square multipliers for offset times step
    assign w_a0 = i_cmd.map_sel ? 32'(r_dx) : r_zr;
    assign w_b0 = i_cmd.map_sel ? w_step    : r_zr;
    assign w_a1 = i_cmd.map_sel ? 32'(r_dy) : r_zi;
    assign w_b1 = i_cmd.map_sel ? w_step    : r_zi;

    assign w_sr    = r_p0 >>> FRAC_BITS;
    assign w_si    = r_p1 >>> FRAC_BITS;
    assign w_cross = r_p2 >>> (FRAC_BITS - 1);
    assign w_mag   = w_sr + w_si;
    assign w_nr    = sat32(w_sr - w_si + 64'(i_cfg.c_real));
    assign w_ni    = sat32(w_cross + 64'(i_cfg.c_imag));

    assign o_sts.escape   = (w_mag > FOUR_FX);
    assign o_sts.at_limit = (r_count >= r_limit);

    assign o_iter_count = r_res_count;
    assign o_escaped    = r_res_esc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx    <= $signed({1'b0, i_pixel_x}) - $signed({1'b0, i_cfg.center_x});
            r_dy    <= $signed({1'b0, i_cfg.center_y}) - $signed({1'b0, i_pixel_y});
            r_limit <= eff_limit(i_cfg.iter_limit);
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_count <= r_count + 10'd1;
        end
        if (i_cmd.mul) begin
            r_p0 <= w_a0 * w_b0;
            r_p1 <= w_a1 * w_b1;
            r_p2 <= r_zr * r_zi;
        end
        if (i_cmd.start) begin
            r_zr <= sat32(r_p0);
            r_zi <= sat32(r_p1);
        end else if (i_cmd.step) begin
            r_zr <= w_nr;
            r_zi <= w_ni;
        end
        if (i_cmd.finish) begin
            r_res_count <= r_count;
            r_res_esc   <= o_sts.escape;
        end
    end

endmodule

[rtl/jetp_ctrl.sv]
// controller: pixel sequencing state machine and output beat valid
// depends on jetp_pkg
`timescale 1ns / 1ps

module jetp_ctrl
    import jetp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_done;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_done      = i_sts.escape || i_sts.at_limit;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MAP;
            S_MAP:   n_state = S_START;
            S_START: n_state = S_MUL;
            S_MUL:   n_state = S_EVAL;
            S_EVAL: begin
                if (!w_done) begin
                    n_state = S_MUL;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load = i_in_valid;
            S_MAP: begin
                o_cmd.mul     = 1'b1;
                o_cmd.map_sel = 1'b1;
            end
            S_START: o_cmd.start = 1'b1;
            S_MUL:   o_cmd.mul   = 1'b1;
            S_EVAL: begin
                o_cmd.step   = !w_done;
                o_cmd.finish = w_done && w_out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
